// ===== design/spq_pkg.sv =====
// Package for the sorted priority queue unit.
// Holds the command and status codes, the fixed field widths and the cell control struct.
// No dependencies.
package spq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

// ===== design/spq_in_if.sv =====
// Input channel of the sorted priority queue: valid/ready plus command and value.
// Depends on spq_pkg.
interface spq_in_if
  import spq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== design/spq_out_if.sv =====
// Result channel of the sorted priority queue: valid/ready plus the result fields.
// Depends on spq_pkg.
interface spq_out_if
  import spq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [VALUE_W-1:0]  removed_value;
  logic signed [VALUE_W-1:0]  head_value;
  logic [COUNT_W-1:0]         entry_count;
  logic                       is_empty;
  logic                       is_full;

  modport source (output valid, output status, output removed_value, output head_value,
                  output entry_count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input removed_value, input head_value,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

// ===== design/spq_cell.sv =====
// One compare-and-shift cell of the sorted chain: holds one key.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned IDX       = 0
) (
  input  logic                        clk,
  input  cell_ctrl_t                  ctrl,
  input  logic signed [KEY_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]            count,
  input  logic                        left_gt,
  input  logic signed [KEY_WIDTH-1:0] left_entry,
  input  logic signed [KEY_WIDTH-1:0] right_entry,
  output logic                        gt,
  output logic signed [KEY_WIDTH-1:0] entry
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [KEY_WIDTH-1:0] entry_r;
  logic signed [KEY_WIDTH-1:0] entry_nxt;
  logic                        occupied;

  assign occupied = (IDX_C < count);
  // Stored key is strictly greater than the new one: it moves one place up.
  assign gt       = occupied && (entry_r > key);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || (IDX_C == count)) begin
        entry_nxt = key;
      end
    end else if (ctrl.rem_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== design/sorted_priority_queue_unit.sv =====
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid/ready   | command, value
// out_ch   | out | valid/ready   | status, removed_value, head_value, entry_count,
//          |     |               | is_empty, is_full
//
// One item per cycle while the output register is empty or being drained; its result appears
// in the output register in the cycle after acceptance. Insert and remove update every cell of the chain together.
// in_ch.ready is high while the output register is empty or being drained.
// Synchronous active-low reset empties the queue; stored keys are not cleared.
//
// Top level of the sorted priority queue; depends on spq_pkg, spq_in_if, spq_out_if, spq_cell.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        accept;
  logic                        q_full;
  logic                        q_empty;
  logic [63:0]                 value_wide;
  logic signed [KEY_WIDTH-1:0] key;
  cell_ctrl_t                  ctrl;

  logic signed [KEY_WIDTH-1:0] entry [DEPTH];
  logic                        gt    [DEPTH];

  logic                        out_valid_r;
  status_t                     status_r,  status_nxt;
  logic signed [VALUE_W-1:0]   removed_r, removed_nxt;
  logic signed [VALUE_W-1:0]   head_r,    head_nxt;
  logic [COUNT_W-1:0]          ecount_r;
  logic                        empty_r;
  logic                        full_r;

  // Sign-extend a key and keep the low bits of the result field.
  function automatic logic signed [VALUE_W-1:0] key_out(input logic signed [KEY_WIDTH-1:0] k);
    logic signed [63:0] ext;
    ext = 64'(k);
    return ext[VALUE_W-1:0];
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign value_wide  = {32'b0, in_ch.value};
  assign key         = value_wide[KEY_WIDTH-1:0];

  assign q_full      = (count_r == DEPTH_C);
  assign q_empty     = (count_r == '0);

  always_comb begin
    ctrl.ins_en = accept && (in_ch.command == CMD_INSERT) && !q_full;
    ctrl.rem_en = accept && (in_ch.command == CMD_REMOVE) && !q_empty;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        left_gt;
    logic signed [KEY_WIDTH-1:0] left_entry;
    logic signed [KEY_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = key;
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_notlast
      assign right_entry = entry[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .count       (count_r),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .gt          (gt[i]),
      .entry       (entry[i])
    );
  end

  // Result of the accepted item, computed from the state before the update.
  always_comb begin
    status_nxt  = STATUS_OK;
    removed_nxt = '0;
    head_nxt    = q_empty ? '0 : key_out(entry[0]);
    if (in_ch.command == CMD_INSERT) begin
      if (q_full) begin
        status_nxt = STATUS_OVERFLOW;
      end else if (q_empty || (key < entry[0])) begin
        head_nxt = key_out(key);
      end
    end else begin
      if (q_empty) begin
        status_nxt = STATUS_UNDERFLOW;
      end else begin
        removed_nxt = key_out(entry[0]);
        head_nxt    = (count_r == CNT_W'(1)) ? '0 : key_out(entry[1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      head_r    <= head_nxt;
      ecount_r  <= COUNT_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
      full_r    <= (count_nxt == DEPTH_C);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.head_value    = head_r;
  assign out_ch.entry_count   = ecount_r;
  assign out_ch.is_empty      = empty_r;
  assign out_ch.is_full       = full_r;

endmodule

// ===== design/spq_checker.sv =====
// Port-level assertions for the sorted priority queue unit, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
module spq_checker
  import spq_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic signed [VALUE_W-1:0] removed_value,
  input logic [COUNT_W-1:0]        entry_count,
  input logic                      is_empty,
  input logic                      is_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STATUS_OVERFLOW) |-> is_full && !is_empty)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STATUS_UNDERFLOW) |-> is_empty && (removed_value == '0))
    else $error("underflow with entries left or a removed key");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> (entry_count == '0) && !is_full)
    else $error("empty flag disagrees with count");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .removed_value (out_ch.removed_value),
  .entry_count   (out_ch.entry_count),
  .is_empty      (out_ch.is_empty),
  .is_full       (out_ch.is_full)
);

// ===== dv/sorted_priority_queue_unit_tb.sv =====
// Self-checking testbench for sorted_priority_queue_unit: drives insert/remove items,
// predicts status, removed key, head, count and flags from a sorted key list.
// Depends on spq_pkg, spq_in_if, spq_out_if and the unit itself.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  removed;
    logic signed [VALUE_W-1:0]  head;
    logic [COUNT_W-1:0]         count;
    logic                       empty;
    logic                       full;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_unit #(
    .DEPTH     (QUEUE_DEPTH),
    .KEY_WIDTH (VALUE_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [VALUE_W-1:0] stored_keys[$];
  queue_result_t             pending_results[$];
  int                        error_count = 0;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Key list after one command; equal keys go behind the ones already stored.
  function automatic queue_result_t step_sorted_queue(cmd_t cmd,
                                                      logic signed [VALUE_W-1:0] key);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (stored_keys.size() >= QUEUE_DEPTH) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        pos = stored_keys.size();
        while (pos > 0 && stored_keys[pos-1] > key) pos--;
        stored_keys.insert(pos, key);
      end
    end else if (stored_keys.size() == 0) begin
      r.status = STATUS_UNDERFLOW;
    end else begin
      r.removed = stored_keys.pop_front();
    end
    if (stored_keys.size() != 0) r.head = stored_keys[0];
    r.count = COUNT_W'(stored_keys.size());
    r.empty = (stored_keys.size() == 0);
    r.full  = (stored_keys.size() == QUEUE_DEPTH);
    return r;
  endfunction

  // Mix of wide random keys, a narrow band for duplicates, extremes and copies of stored keys.
  function automatic logic signed [VALUE_W-1:0] pick_key();
    case ($urandom_range(9))
      5, 6, 7: return $signed(VALUE_W'($urandom_range(8))) - 4;
      8: begin
        case ($urandom_range(3))
          0:       return KEY_MAX;
          1:       return KEY_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
      9: begin
        if (stored_keys.size() != 0)
          return stored_keys[$urandom_range(stored_keys.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic signed [VALUE_W-1:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        in_ch.command <= 1'($urandom_range(1));
        in_ch.value   <= $urandom;
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= key;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(step_sorted_queue(cmd, key));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pressure(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Underflow on empty, extreme keys, duplicates, then removal in sorted order down to a second underflow.
  task automatic test_directed_keys();
    send_item(CMD_REMOVE, KEY_MAX);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, KEY_MAX);
    send_item(CMD_INSERT, KEY_MIN);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 1);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, KEY_MIN);
    send_item(CMD_INSERT, KEY_MAX);
    repeat (8) send_item(CMD_REMOVE, $urandom);
    send_item(CMD_REMOVE, KEY_MIN);
  endtask

  // Fill to capacity, hit overflow, empty it again and hit underflow.
  task automatic test_fill_and_drain();
    while (stored_keys.size() < QUEUE_DEPTH) send_item(CMD_INSERT, pick_key());
    send_item(CMD_INSERT, pick_key());
    repeat (QUEUE_DEPTH + 1) send_item(CMD_REMOVE, $urandom);
  endtask

  // Runs of insert-heavy, remove-heavy or balanced traffic so the count sweeps its range.
  task automatic test_random_traffic(int n_items);
    int sent;
    int run_len;
    int insert_pct;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(20, 90);
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      repeat (run_len) begin
        if ($urandom_range(99) < insert_pct) send_item(CMD_INSERT, pick_key());
        else send_item(CMD_REMOVE, $urandom);
        sent++;
      end
    end
  endtask

  task automatic report_field(string field, logic [VALUE_W-1:0] exp_v,
                              logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, status %0d head %0h count %0d",
                 $time, out_ch.status, out_ch.head_value, out_ch.entry_count);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        report_field("status", exp_r.status, out_ch.status);
        report_field("removed_value", exp_r.removed, out_ch.removed_value);
        report_field("head_value", exp_r.head, out_ch.head_value);
        report_field("entry_count", exp_r.count, out_ch.entry_count);
        report_field("is_empty", exp_r.empty, out_ch.is_empty);
        report_field("is_full", exp_r.full, out_ch.is_full);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("sorted_priority_queue_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_INSERT;
    in_ch.value    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_pressure(0, 0);
    test_directed_keys();
    test_fill_and_drain();
    test_random_traffic(160);
    drain_results();

    set_pressure(49, 0);
    test_random_traffic(160);
    drain_results();

    set_pressure(0, 49);
    test_random_traffic(160);
    drain_results();

    set_pressure(6, 6);
    test_fill_and_drain();
    test_random_traffic(160);
    drain_results();

    if (error_count == 0) begin
      $display("sorted_priority_queue_unit regression: pass");
    end else begin
      $display("sorted_priority_queue_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/spq_in_if.sv
design/spq_out_if.sv
design/spq_cell.sv
design/sorted_priority_queue_unit.sv
design/spq_checker.sv
dv/sorted_priority_queue_unit_tb.sv
